// File: rtl/core/kfd_pkg.sv
package kfd_pkg;

    localparam int DEPTH  = 16;
    localparam int KEY_W  = 64;
    localparam int TIME_W = 48;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
    localparam logic [OP_W-1:0] OP_POP      = 3'd1;
    localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE    = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd4;

    // result kinds
    localparam logic [OP_W-1:0] KIND_PUSH     = 3'd0;
    localparam logic [OP_W-1:0] KIND_POP      = 3'd1;
    localparam logic [OP_W-1:0] KIND_CONTAINS = 3'd2;
    localparam logic [OP_W-1:0] KIND_ERASE    = 3'd3;
    localparam logic [OP_W-1:0] KIND_EXPIRY   = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_DUP       = 2'd3;

    typedef struct packed {
        logic accept;
        logic read;
        logic eval;
        logic finish;
    } kfd_cmd_t;

    typedef struct packed {
        logic op_ok;
        logic scan_done;
        logic ev_stall;
        logic fin_stall;
    } kfd_sts_t;

endpackage

// File: rtl/core/kfd_req_if.sv
interface kfd_req_if
    import kfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] deadline;

    modport source (output valid, operation, key, deadline, input ready);
    modport sink   (input valid, operation, key, deadline, output ready);
endinterface

// File: rtl/core/kfd_rsp_if.sv
interface kfd_rsp_if
    import kfd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  kind;
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] result_key;
    logic             found;
    logic [CNT_W-1:0] occupancy;
    logic             last;

    modport source (output valid, kind, status, result_key, found, occupancy, last,
                    input ready);
    modport sink   (input valid, kind, status, result_key, found, occupancy, last,
                    output ready);
endinterface

// File: rtl/core/kfd_ctrl.sv
module kfd_ctrl
    import kfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  kfd_sts_t  sts,
    output kfd_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.op_ok)
                        state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (sts.scan_done)
                    state_next = S_FIN;
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = S_EV;
                end
            end
            S_EV:
            begin
                // hold while an expiry waits for the output register
                if (!sts.ev_stall)
                begin
                    cmd.eval   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                if (!sts.fin_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/core/kfd_datapath.sv
module kfd_datapath
    import kfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  kfd_cmd_t          cmd,
    output kfd_sts_t          sts,
    input  logic [OP_W-1:0]   req_operation,
    input  logic [KEY_W-1:0]  req_key,
    input  logic [TIME_W-1:0] req_deadline,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output logic [OP_W-1:0]   rsp_kind,
    output logic [ST_W-1:0]   rsp_status,
    output logic [KEY_W-1:0]  rsp_result_key,
    output logic              rsp_found,
    output logic [CNT_W-1:0]  rsp_occupancy,
    output logic              rsp_last
);

    logic [KEY_W-1:0]  mem_key [DEPTH];
    logic [TIME_W-1:0] mem_dl  [DEPTH];

    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] dl_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TIME_W-1:0] time_reg;
    logic [CNT_W-1:0]  scan_len_reg;
    logic [CNT_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  wr_ptr_reg;
    logic              hit_reg;
    logic [KEY_W-1:0]  rkey_reg;
    logic [TIME_W-1:0] rdl_reg;
    logic              pend_valid_reg;
    logic [KEY_W-1:0]  pend_key_reg;
    logic [CNT_W-1:0]  pend_occ_reg;

    logic              out_valid_reg;
    logic [OP_W-1:0]   out_kind_reg;
    logic [ST_W-1:0]   out_status_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic              out_found_reg;
    logic [CNT_W-1:0]  out_occ_reg;
    logic              out_last_reg;

    logic              match;
    logic              is_tick;
    logic              drop;
    logic              out_free;
    logic              out_set;
    logic              ev_emit;
    logic              fin_emit;
    logic              full;
    logic              push_ok;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [KEY_W-1:0]  mem_wkey;
    logic [TIME_W-1:0] mem_wdl;
    logic [OP_W-1:0]   fin_kind;
    logic [ST_W-1:0]   fin_status;
    logic [KEY_W-1:0]  fin_key;
    logic              fin_found;
    logic [CNT_W-1:0]  fin_occ;

    always_comb
    begin
        match    = (rkey_reg == key_reg);
        is_tick  = (op_reg == OP_TICK);
        full     = (count_reg == CNT_W'(DEPTH));
        push_ok  = !full && !hit_reg;
        out_free = !out_valid_reg || rsp_ready;

        case (op_reg)
            OP_POP:   drop = (rd_ptr_reg == '0);
            OP_ERASE: drop = match && !hit_reg;
            OP_TICK:  drop = (rdl_reg <= time_reg);
            default:  drop = 1'b0;
        endcase

        ev_emit  = is_tick && drop && pend_valid_reg;
        fin_emit = !is_tick || pend_valid_reg;
        out_set  = (cmd.eval && ev_emit) || (cmd.finish && fin_emit);

        sts.op_ok     = (req_operation <= OP_TICK);
        sts.scan_done = (rd_ptr_reg == scan_len_reg);
        sts.ev_stall  = ev_emit && !out_free;
        sts.fin_stall = fin_emit && !out_free;
    end

    // closing result of the operation
    always_comb
    begin
        fin_kind   = op_reg;
        fin_status = ST_OK;
        fin_key    = '0;
        fin_found  = 1'b0;
        fin_occ    = count_reg;
        case (op_reg)
            OP_PUSH:
            begin
                fin_kind = KIND_PUSH;
                if (full)
                    fin_status = ST_FULL;
                else if (hit_reg)
                    fin_status = ST_DUP;
                else
                    fin_occ = count_reg + CNT_W'(1);
            end
            OP_POP:
            begin
                fin_kind   = KIND_POP;
                fin_status = hit_reg ? ST_OK : ST_NOT_FOUND;
                fin_key    = hit_reg ? pend_key_reg : '0;
            end
            OP_CONTAINS:
            begin
                fin_kind  = KIND_CONTAINS;
                fin_found = hit_reg;
            end
            OP_ERASE:
            begin
                fin_kind   = KIND_ERASE;
                fin_status = hit_reg ? ST_OK : ST_NOT_FOUND;
            end
            default:
            begin
                fin_kind = KIND_EXPIRY;
                fin_key  = pend_key_reg;
                fin_occ  = pend_occ_reg;
            end
        endcase
    end

    // one write port: compaction during the scan, append at the end of a push
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_ptr_reg[IDX_W-1:0];
        mem_wkey  = rkey_reg;
        mem_wdl   = rdl_reg;
        if (cmd.eval && !drop)
            mem_we = 1'b1;
        else if (cmd.finish && op_reg == OP_PUSH && push_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[IDX_W-1:0];
            mem_wkey  = key_reg;
            mem_wdl   = dl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_key[mem_waddr] <= mem_wkey;
            mem_dl[mem_waddr]  <= mem_wdl;
        end
        if (cmd.read)
        begin
            rkey_reg <= mem_key[rd_ptr_reg[IDX_W-1:0]];
            rdl_reg  <= mem_dl[rd_ptr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= OP_PUSH;
            count_reg      <= '0;
            time_reg       <= '0;
            scan_len_reg   <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_set)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;

            if (cmd.accept)
            begin
                op_reg         <= req_operation;
                scan_len_reg   <= count_reg;
                rd_ptr_reg     <= '0;
                wr_ptr_reg     <= '0;
                hit_reg        <= 1'b0;
                pend_valid_reg <= 1'b0;
                if (req_operation == OP_TICK)
                    time_reg <= time_reg + TIME_W'(1);
            end

            if (cmd.eval)
            begin
                rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                if (drop)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                    if (is_tick)
                        pend_valid_reg <= 1'b1;
                    else
                        hit_reg <= 1'b1;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + CNT_W'(1);
                    if ((op_reg == OP_PUSH || op_reg == OP_CONTAINS) && match)
                        hit_reg <= 1'b1;
                end
            end

            if (cmd.finish)
            begin
                if (op_reg == OP_PUSH && push_ok)
                    count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= req_key;
            dl_reg  <= req_deadline;
        end
        if (cmd.eval && drop)
        begin
            pend_key_reg <= rkey_reg;
            pend_occ_reg <= count_reg - CNT_W'(1);
        end
        if (cmd.eval && ev_emit)
        begin
            // release the previous expiry; a later one follows it
            out_kind_reg   <= KIND_EXPIRY;
            out_status_reg <= ST_OK;
            out_key_reg    <= pend_key_reg;
            out_found_reg  <= 1'b0;
            out_occ_reg    <= pend_occ_reg;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.finish && fin_emit)
        begin
            out_kind_reg   <= fin_kind;
            out_status_reg <= fin_status;
            out_key_reg    <= fin_key;
            out_found_reg  <= fin_found;
            out_occ_reg    <= fin_occ;
            out_last_reg   <= 1'b1;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_kind       = out_kind_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_result_key = out_key_reg;
    assign rsp_found      = out_found_reg;
    assign rsp_occupancy  = out_occ_reg;
    assign rsp_last       = out_last_reg;

endmodule

// File: rtl/core/keyed_fifo_with_deadline_expiry.sv
// Keyed timeout queue of up to DEPTH keys, kept oldest first, each with a
// deadline in ticks.
// req channel (sink): operation, key, deadline. One transfer per command:
//   push, pop oldest, contains, erase by key, tick. Codes above tick are
//   taken and dropped without a result.
// rsp channel (source): kind, status, result_key, found, occupancy, last.
//   Push, pop, contains and erase give one result; a tick gives one expiry
//   per entry whose deadline is at or before the advanced time, oldest
//   first, or none. last marks the final result of a command.
// Sequencing: one command is worked at a time. The entry store has one read
//   port and is swept one entry at a time, each read and then evaluated; the
//   final result of a command is registered once the sweep over the N entries
//   occupied when it was taken is done, and req is ready again from the cycle
//   in which that result appears. No new command is taken during the sweep.
// Output: a single result register. A waiting result does not block the
//   next command being taken; the sweep holds only when it must hand over
//   a further result while the register is still full. A stalled receiver
//   thus holds the block at most one result deep, with the payload steady.
// Reset: queue empty, current time zero, no result pending. Entry contents
//   are not cleared; only the occupied span is ever read.
module keyed_fifo_with_deadline_expiry
    import kfd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    kfd_req_if.sink   req,
    kfd_rsp_if.source rsp
);

    kfd_cmd_t cmd;
    kfd_sts_t sts;

    // sequencer: idle, read, evaluate, finish
    kfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // entry store, sweep pointers, occupancy, time and the result register
    kfd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_operation  (req.operation),
        .req_key        (req.key),
        .req_deadline   (req.deadline),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_kind       (rsp.kind),
        .rsp_status     (rsp.status),
        .rsp_result_key (rsp.result_key),
        .rsp_found      (rsp.found),
        .rsp_occupancy  (rsp.occupancy),
        .rsp_last       (rsp.last)
    );

endmodule

// File: rtl/core/kfd_checker.sv
module kfd_checker
    import kfd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [OP_W-1:0]  rsp_kind,
    input logic [ST_W-1:0]  rsp_status,
    input logic [KEY_W-1:0] rsp_result_key,
    input logic             rsp_found,
    input logic [CNT_W-1:0] rsp_occupancy,
    input logic             rsp_last
);

    // a held result stays put until transferred
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
            && $stable(rsp_result_key) && $stable(rsp_occupancy) && $stable(rsp_last))
        else $error("result changed while stalled");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_occupancy <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_found_only_contains: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind != KIND_CONTAINS |-> !rsp_found)
        else $error("found set outside a contains reply");

    a_single_replies_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_kind != KIND_EXPIRY |-> rsp_last)
        else $error("command reply not marked last");

    a_expiry_ok_keyless_replies: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == KIND_PUSH || rsp_kind == KIND_CONTAINS
            || rsp_kind == KIND_ERASE || rsp_kind == KIND_EXPIRY)
        |-> (rsp_kind == KIND_EXPIRY ? rsp_status == ST_OK : rsp_result_key == '0))
        else $error("key on a keyless reply or failing expiry");

endmodule

bind keyed_fifo_with_deadline_expiry kfd_checker u_kfd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_kind       (rsp.kind),
    .rsp_status     (rsp.status),
    .rsp_result_key (rsp.result_key),
    .rsp_found      (rsp.found),
    .rsp_occupancy  (rsp.occupancy),
    .rsp_last       (rsp.last)
);
